// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and defaults shared by the buddy allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TOP_BLOCKS_DEF    = 32;
  localparam int TOP_ORDER_DEF     = 10;
  localparam int MIN_BLOCK_LOG_DEF = 7;
  localparam int META_BYTES_DEF    = 64;

  localparam int ORD_W = 5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_BIG     = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [26:0] request_size;
    logic [21:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [21:0] granted_offset;
    logic [3:0]  granted_order;
    logic [15:0] free_block_count;
    logic [15:0] total_block_count;
    logic [22:0] free_byte_total;
  } out_item_t;

  typedef struct packed {
    logic             live;
    logic             in_use;
    logic [ORD_W-1:0] order;
  } gran_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_SPLIT,
    S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_FIN, S_OUT
  } state_t;

endpackage

// File: design/bba_gran_ram.sv
// ----------------------------------------------------------------------------
// bba_gran_ram
// Per-granule block record store, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_gran_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bba_pkg::gran_t  wdata,
  input  logic [AW-1:0]   raddr,
  output bba_pkg::gran_t  rdata
);

  bba_pkg::gran_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator: block search, split and buddy merge over a granule store.
// ----------------------------------------------------------------------------
//  channel | signals                     | item
//  in      | in_valid in_ready in_data   | kind, request_size, block_offset
//  out     | out_valid out_ready out_data| status, offset, order, counters
//
//  After reset a clearing pass writes every granule record, in_ready low
//  meanwhile. After the accept cycle, alloc reads and checks candidate blocks
//  (S_A_RD, S_A_CHK) from the requested order up, then splits one level per
//  S_SPLIT step and marks the block; free reads and checks the block, then the
//  buddy per merge level (S_M_RD, S_M_CHK), and writes the merged block in
//  S_FIN. The result is held until taken, then the next item.
module buddy_block_allocator #(
  parameter int TOP_BLOCKS    = bba_pkg::TOP_BLOCKS_DEF,
  parameter int TOP_ORDER     = bba_pkg::TOP_ORDER_DEF,
  parameter int MIN_BLOCK_LOG = bba_pkg::MIN_BLOCK_LOG_DEF,
  parameter int META_BYTES    = bba_pkg::META_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::out_item_t out_data
);

  localparam int NGRAN = TOP_BLOCKS << TOP_ORDER;
  localparam int GW    = $clog2(TOP_BLOCKS) + TOP_ORDER;
  localparam int OW    = bba_pkg::ORD_W;
  localparam int SW    = MIN_BLOCK_LOG + TOP_ORDER + 2;
  localparam int CW    = (SW > 28) ? SW : 28;
  localparam logic [GW:0]   NGRAN_V = NGRAN[GW:0];
  localparam logic [OW-1:0] TOP_V   = TOP_ORDER[OW-1:0];
  localparam logic [63:0]   POOL_BYTES =
      64'(TOP_BLOCKS) << (MIN_BLOCK_LOG + TOP_ORDER);
  localparam logic [15:0] TOP_CNT = TOP_BLOCKS[15:0];

  bba_pkg::state_t state, state_next;

  logic [GW:0]   cnt;
  logic [GW:0]   g;
  logic [OW-1:0] o;
  logic [OW-1:0] want;
  logic [2:0]    status;
  logic [15:0]   free_cnt;
  logic [15:0]   all_blocks;
  logic [22:0]   free_byte_cnt;

  logic           we;
  logic [GW-1:0]  waddr;
  logic [GW-1:0]  raddr;
  bba_pkg::gran_t wdata;
  bba_pkg::gran_t rd;

  bba_gran_ram #(.DEPTH(NGRAN), .AW(GW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd)
  );

  // request decode
  logic [27:0]   need;
  logic [OW-1:0] want_c;
  logic          big;
  always_comb begin
    need   = {1'b0, in_data.request_size} + 28'(META_BYTES);
    want_c = '0;
    big    = 1'b1;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (CW'(need) <= (CW'(1) << (MIN_BLOCK_LOG + k))) begin
        want_c = OW'(k);
        big    = 1'b0;
      end
    end
  end

  // free decode
  logic [31:0] off_gran;
  logic        off_bad;
  always_comb begin
    off_gran = 32'(in_data.block_offset >> MIN_BLOCK_LOG);
    off_bad  = (in_data.block_offset & 22'((1 << MIN_BLOCK_LOG) - 1)) != '0 ||
               off_gran >= 32'(NGRAN);
  end

  logic [GW:0]   step;
  logic [GW:0]   g_adv;
  logic [GW:0]   up;
  logic [GW:0]   bud;
  logic [OW-1:0] o_dn;
  logic [OW-1:0] o_clamp;
  logic [22:0]   bsize;
  logic          hit;
  logic          mhit;
  always_comb begin
    step    = (GW+1)'(1) << o;
    g_adv   = g + step;
    o_dn    = o - OW'(1);
    up      = g + ((GW+1)'(1) << o_dn);
    bud     = g ^ step;
    o_clamp = (rd.order > TOP_V) ? TOP_V : rd.order;
    bsize   = 23'(64'(1) << (MIN_BLOCK_LOG + 32'(o)));
    hit     = rd.live && !rd.in_use && rd.order == o;
    mhit    = hit && bud < NGRAN_V;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_CLEAR: if (cnt == NGRAN_V - (GW+1)'(1)) state_next = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == bba_pkg::KIND_ALLOC) begin
            if (in_data.request_size == '0 || big) state_next = bba_pkg::S_OUT;
            else state_next = bba_pkg::S_A_RD;
          end else begin
            state_next = off_bad ? bba_pkg::S_OUT : bba_pkg::S_F_RD;
          end
        end
      end
      bba_pkg::S_A_RD: state_next = bba_pkg::S_A_CHK;
      bba_pkg::S_A_CHK: begin
        if (hit) state_next = bba_pkg::S_SPLIT;
        else if (g_adv >= NGRAN_V && o == TOP_V) state_next = bba_pkg::S_OUT;
        else state_next = bba_pkg::S_A_RD;
      end
      bba_pkg::S_SPLIT: if (o == want) state_next = bba_pkg::S_OUT;
      bba_pkg::S_F_RD: state_next = bba_pkg::S_F_CHK;
      bba_pkg::S_F_CHK: begin
        state_next = (rd.live && rd.in_use) ? bba_pkg::S_M_RD : bba_pkg::S_OUT;
      end
      bba_pkg::S_M_RD: state_next = (o >= TOP_V) ? bba_pkg::S_FIN : bba_pkg::S_M_CHK;
      bba_pkg::S_M_CHK: state_next = mhit ? bba_pkg::S_M_RD : bba_pkg::S_FIN;
      bba_pkg::S_FIN: state_next = bba_pkg::S_OUT;
      bba_pkg::S_OUT: if (out_ready) state_next = bba_pkg::S_IDLE;
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    waddr     = g[GW-1:0];
    wdata     = '0;
    raddr     = g[GW-1:0];
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      bba_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[GW-1:0];
        if (cnt[TOP_ORDER-1:0] == '0) wdata = '{live: 1'b1, in_use: 1'b0, order: TOP_V};
      end
      bba_pkg::S_IDLE: in_ready = 1'b1;
      bba_pkg::S_SPLIT: begin
        we = 1'b1;
        if (o != want) begin
          waddr = up[GW-1:0];
          wdata = '{live: 1'b1, in_use: 1'b0, order: o_dn};
        end else begin
          wdata = '{live: 1'b1, in_use: 1'b1, order: o};
        end
      end
      bba_pkg::S_M_RD: raddr = bud[GW-1:0];
      bba_pkg::S_M_CHK: begin
        if (mhit) begin
          we    = 1'b1;
          waddr = (g < bud) ? bud[GW-1:0] : g[GW-1:0];
        end
      end
      bba_pkg::S_FIN: begin
        we    = 1'b1;
        wdata = '{live: 1'b1, in_use: 1'b0, order: o};
      end
      bba_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bba_pkg::S_CLEAR;
      cnt           <= '0;
      free_cnt      <= TOP_CNT;
      all_blocks    <= TOP_CNT;
      free_byte_cnt <= POOL_BYTES[22:0];
    end else begin
      state <= state_next;
      unique case (state)
        bba_pkg::S_CLEAR: cnt <= cnt + (GW+1)'(1);
        bba_pkg::S_IDLE: begin
          if (in_valid) begin
            status <= bba_pkg::ST_OK;
            g      <= '0;
            o      <= want_c;
            want   <= want_c;
            if (in_data.kind == bba_pkg::KIND_ALLOC) begin
              if (in_data.request_size == '0) status <= bba_pkg::ST_ZERO;
              else if (big) status <= bba_pkg::ST_BIG;
            end else begin
              if (off_bad) status <= bba_pkg::ST_IGNORED;
              g <= off_gran[GW:0];
            end
          end
        end
        bba_pkg::S_A_CHK: begin
          if (!hit) begin
            if (g_adv >= NGRAN_V) begin
              if (o == TOP_V) status <= bba_pkg::ST_NONE;
              else begin
                o <= o + OW'(1);
                g <= '0;
              end
            end else begin
              g <= g_adv;
            end
          end
        end
        bba_pkg::S_SPLIT: begin
          if (o != want) begin
            o          <= o_dn;
            all_blocks <= all_blocks + 16'd1;
            free_cnt   <= free_cnt + 16'd1;
          end else begin
            free_cnt      <= free_cnt - 16'd1;
            free_byte_cnt <= free_byte_cnt - bsize;
          end
        end
        bba_pkg::S_F_CHK: begin
          if (rd.live && rd.in_use) begin
            o             <= o_clamp;
            free_cnt      <= free_cnt + 16'd1;
            free_byte_cnt <= free_byte_cnt +
                             23'(64'(1) << (MIN_BLOCK_LOG + 32'(o_clamp)));
          end else begin
            status <= bba_pkg::ST_IGNORED;
          end
        end
        bba_pkg::S_M_CHK: begin
          if (mhit) begin
            if (bud < g) g <= bud;
            o          <= o + OW'(1);
            free_cnt   <= free_cnt - 16'd1;
            all_blocks <= all_blocks - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.status            = status;
    out_data.granted_offset    = '0;
    out_data.granted_order     = '0;
    if (status == bba_pkg::ST_OK) begin
      out_data.granted_offset = 22'(32'(g) << MIN_BLOCK_LOG);
      out_data.granted_order  = o[3:0];
    end
    out_data.free_block_count  = free_cnt;
    out_data.total_block_count = all_blocks;
    out_data.free_byte_total   = free_byte_cnt;
  end

endmodule

// File: tb/tb_buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench for the buddy allocator. It runs directed corner items,
// a pool fill to exhaustion, then random alloc/free traffic with random
// stalls on both channels. Each result is compared against a local model
// that tracks the free map, the block records and the counters.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;

  localparam int NGRAN   = 32 << 10;
  localparam int TOP_ORD = 10;
  localparam int GRAN_LG = 7;
  localparam int HDR     = 64;

  class alloc_scoreboard;
    bit       free_map [0:TOP_ORD][0:NGRAN-1];
    bit [3:0] blk_order [0:NGRAN-1];
    bit       blk_live [0:NGRAN-1];
    bit       blk_used [0:NGRAN-1];
    int       free_cnt;
    int       blk_cnt;
    longint   free_byte_cnt;
    bba_pkg::out_item_t pending_results[$];
    int       live_offsets[$];
    int       errors;
    int       n_alloc_ok, n_free_ok, n_rejected;

    function new();
      for (int t = 0; t < 32; t++) begin
        blk_order[t << TOP_ORD] = 4'(TOP_ORD);
        blk_live[t << TOP_ORD] = 1;
        free_map[TOP_ORD][t] = 1;
      end
      free_cnt = 32;
      blk_cnt = 32;
      free_byte_cnt = 64'd32 << (TOP_ORD + GRAN_LG);
    endfunction

    function logic [2:0] do_alloc(int req, output int goff, output int gord);
      int want, o, g;
      bit found;
      found = 0;
      g = 0;
      if (req == 0) return bba_pkg::ST_ZERO;
      for (want = 0; want <= TOP_ORD; want++)
        if (req + HDR <= (1 << (GRAN_LG + want))) break;
      if (want > TOP_ORD) return bba_pkg::ST_BIG;
      for (o = want; o <= TOP_ORD && !found; o++)
        for (int i = 0; i < (NGRAN >> o) && !found; i++)
          if (free_map[o][i]) begin
            g = i << o;
            found = 1;
          end
      if (!found) return bba_pkg::ST_NONE;
      o--;
      while (o > want) begin
        int up;
        free_map[o][g >> o] = 0;
        o--;
        up = g + (1 << o);
        blk_order[g] = 4'(o);
        blk_live[up] = 1;
        blk_used[up] = 0;
        blk_order[up] = 4'(o);
        free_map[o][g >> o] = 1;
        free_map[o][up >> o] = 1;
        blk_cnt++;
        free_cnt++;
      end
      free_map[o][g >> o] = 0;
      blk_used[g] = 1;
      free_cnt--;
      free_byte_cnt -= 1 << (GRAN_LG + o);
      goff = g << GRAN_LG;
      gord = o;
      return bba_pkg::ST_OK;
    endfunction

    function logic [2:0] do_free(int off, output int goff, output int gord);
      int g, o;
      if (off[GRAN_LG-1:0] != 0) return bba_pkg::ST_IGNORED;
      g = off >> GRAN_LG;
      if (g >= NGRAN || !blk_live[g] || !blk_used[g]) return bba_pkg::ST_IGNORED;
      o = blk_order[g];
      blk_used[g] = 0;
      free_cnt++;
      free_byte_cnt += 1 << (GRAN_LG + o);
      while (o < TOP_ORD) begin
        int b;
        b = g ^ (1 << o);
        if (!blk_live[b] || blk_used[b] || blk_order[b] != o) break;
        free_map[o][b >> o] = 0;
        blk_live[g > b ? g : b] = 0;
        blk_order[g > b ? g : b] = 0;
        g = g < b ? g : b;
        o++;
        blk_order[g] = 4'(o);
        free_cnt--;
        blk_cnt--;
      end
      free_map[o][g >> o] = 1;
      goff = g << GRAN_LG;
      gord = o;
      return bba_pkg::ST_OK;
    endfunction

    function void note_input(bba_pkg::in_item_t it);
      bba_pkg::out_item_t r;
      int goff, gord;
      goff = 0;
      gord = 0;
      if (it.kind == bba_pkg::KIND_ALLOC) r.status = do_alloc(it.request_size, goff, gord);
      else r.status = do_free(it.block_offset, goff, gord);
      if (r.status != bba_pkg::ST_OK) begin
        goff = 0;
        gord = 0;
        n_rejected++;
      end else if (it.kind == bba_pkg::KIND_ALLOC) begin
        n_alloc_ok++;
        live_offsets.push_back(goff);
      end else begin
        n_free_ok++;
        foreach (live_offsets[i])
          if (live_offsets[i] == it.block_offset) begin
            live_offsets.delete(i);
            break;
          end
      end
      r.granted_offset = 22'(goff);
      r.granted_order = 4'(gord);
      r.free_block_count = 16'(free_cnt);
      r.total_block_count = 16'(blk_cnt);
      r.free_byte_total = 23'(free_byte_cnt);
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(bba_pkg::out_item_t got);
      bba_pkg::out_item_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %p", got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp("status", e.status, got.status);
      cmp("granted_offset", e.granted_offset, got.granted_offset);
      cmp("granted_order", e.granted_order, got.granted_order);
      cmp("free_block_count", e.free_block_count, got.free_block_count);
      cmp("total_block_count", e.total_block_count, got.total_block_count);
      cmp("free_byte_total", e.free_byte_total, got.free_byte_total);
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  bba_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  bba_pkg::out_item_t out_data;
  bit        no_gaps = 0;
  alloc_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  buddy_block_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send(logic kind, logic [26:0] req, logic [21:0] off);
    bba_pkg::in_item_t it;
    int gap;
    it.kind = kind;
    it.request_size = req;
    it.block_offset = off;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic alloc_bytes(int req);
    send(bba_pkg::KIND_ALLOC, 27'(req), 22'($urandom));
  endtask

  task automatic free_at(int off);
    send(bba_pkg::KIND_FREE, 27'($urandom), 22'(off));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function int size_for_order(int o);
    int lo, hi;
    hi = (1 << (GRAN_LG + o)) - HDR;
    lo = o == 0 ? 1 : (1 << (GRAN_LG + o - 1)) - HDR + 1;
    return $urandom_range(lo, hi);
  endfunction

  always begin
    bba_pkg::out_item_t got;
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(negedge clk); while (!out_valid);
      got = out_data;
      @(posedge clk);
      sb.check_result(got);
    end
  end

  initial begin
    #600000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int o, r, idx;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed corners
    alloc_bytes(1);
    alloc_bytes(64);
    alloc_bytes(65);
    alloc_bytes(0);
    alloc_bytes(131072 - 64);
    alloc_bytes(131072 - 63);
    alloc_bytes(27'h7FFFFFF);
    free_at(1);
    free_at(22'h3FFF80);
    free_at(128 * 3);
    free_at(0);
    free_at(0);
    free_at(128);
    free_at(256);
    free_at(22'h3FFFFF);
    while (sb.live_offsets.size() != 0) free_at(sb.live_offsets.pop_front());

    // fill the pool with top blocks until it runs out
    no_gaps = 1;
    repeat (33) alloc_bytes(131072 - 64);
    alloc_bytes(1);
    no_gaps = 0;
    drain();
    sb.live_offsets.shuffle();
    while (sb.live_offsets.size() != 0) free_at(sb.live_offsets.pop_front());

    for (int n = 0; n < 370; n++) begin
      if (n % 100 == 50) no_gaps = ~no_gaps;
      if (n == 200) drain();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 19) == 0)
          alloc_bytes($urandom_range(0, 1) ? 0 : $urandom_range(131009, 27'h7FFFFFF));
        else begin
          o = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, TOP_ORD);
          alloc_bytes(size_for_order(o));
        end
      end else if (r < 90 && sb.live_offsets.size() != 0) begin
        idx = $urandom_range(0, sb.live_offsets.size() - 1);
        free_at(sb.live_offsets[idx]);
      end else
        free_at($urandom_range(0, 1) ? $urandom : ($urandom & 22'h3FFF80));
    end
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d good allocs, %0d good frees, %0d rejected items",
             sb.n_alloc_ok, sb.n_free_ok, sb.n_rejected);
    $display("including pool exhaustion, merges up to top order and bad frees");
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
